// File: sv/kfrl_pkg.sv
// ---------------------------------------------------------------------------
// kfrl_pkg: shared types and constants
// Function codes, register indexes, queue entry type and FNV-1a constants.
// ---------------------------------------------------------------------------
`default_nettype none
package kfrl_pkg;
    localparam logic [1:0] FUNC_QUERY  = 2'd0;
    localparam logic [1:0] FUNC_RECORD = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [0:0] REG_FAIL_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_WINDOW_SECONDS = 1'b1;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] FAIL_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] WINDOW_FALLBACK = 16'd600;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] lookup_key;
        logic [31:0] now_seconds;
        logic [31:0] hash;
    } kfrl_cmd_t;
endpackage
`default_nettype wire

// File: sv/kfrl_front.sv
// ---------------------------------------------------------------------------
// kfrl_front: input stage and key hash
// Accepts an item, hashes its key one byte per cycle, pushes it to the queue.
// ---------------------------------------------------------------------------
`default_nettype none
module kfrl_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_func,
    input  wire logic [63:0]       in_key,
    input  wire logic [31:0]       in_now,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output kfrl_pkg::kfrl_cmd_t    q_data
);
    import kfrl_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_HASH, S_PUSH} state_t;
    state_t      state_reg;
    logic [2:0]  byte_reg;
    logic [31:0] hash_reg;
    logic [31:0] hash_mix;
    logic [1:0]  func_reg;
    logic [63:0] key_reg;
    logic [31:0] now_reg;
    logic [7:0]  cur_byte;

    always_comb begin
        cur_byte = key_reg[{~byte_reg, 3'b000} +: 8];
        hash_mix = (hash_reg ^ {24'd0, cur_byte}) * FNV_PRIME;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign q_valid  = (state_reg == S_PUSH);
    assign q_data   = '{func: func_reg, lookup_key: key_reg, now_seconds: now_reg,
                        hash: hash_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            byte_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (in_valid) begin
                    func_reg  <= in_func;
                    key_reg   <= in_key;
                    now_reg   <= in_now;
                    hash_reg  <= FNV_BASIS;
                    byte_reg  <= '0;
                    state_reg <= S_HASH;
                end
                S_HASH: begin
                    hash_reg <= hash_mix;
                    byte_reg <= byte_reg + 3'd1;
                    if (byte_reg == 3'd7) state_reg <= S_PUSH;
                end
                S_PUSH: if (q_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/kfrl_queue.sv
// ---------------------------------------------------------------------------
// kfrl_queue: command queue
// Two-entry FIFO between the hash front and the table engine.
// ---------------------------------------------------------------------------
`default_nettype none
module kfrl_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire kfrl_pkg::kfrl_cmd_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output kfrl_pkg::kfrl_cmd_t    rd_data
);
    import kfrl_pkg::*;

    kfrl_cmd_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wptr_reg] <= wr_data;
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (do_wr) wptr_reg <= ~wptr_reg;
            if (do_rd) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule
`default_nettype wire

// File: sv/kfrl_engine.sv
// ---------------------------------------------------------------------------
// kfrl_engine: slot table engine
// Probes the slot window, applies query, record or clear, drives results.
// ---------------------------------------------------------------------------
`default_nettype none
module kfrl_engine #(
    parameter int SLOTS     = 1024,
    parameter int PROBE_LEN = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire kfrl_pkg::kfrl_cmd_t cmd,
    input  wire logic [15:0]       fail_threshold,
    input  wire logic [15:0]       window_seconds,
    input  wire logic              clear_done,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   res_throttled,
    output logic                   res_tripped
);
    import kfrl_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(PROBE_LEN + 1);

    typedef enum logic [2:0] {E_IDLE, E_READ, E_EVAL, E_WRITE, E_DONE} state_t;

    logic          valid_mem [SLOTS];
    logic [63:0]   key_mem   [SLOTS];
    logic [31:0]   start_mem [SLOTS];
    logic [31:0]   fail_mem  [SLOTS];

    state_t        state_reg;
    kfrl_cmd_t     cmd_reg;
    logic [PW-1:0] probe_reg;
    logic [AW-1:0] addr_reg;
    logic          rd_valid_reg;
    logic [63:0]   rd_key_reg;
    logic [31:0]   rd_start_reg, rd_fail_reg;
    logic          have_reuse_reg, have_weak_reg;
    logic [AW-1:0] reuse_reg, weak_reg;
    logic [31:0]   weak_fail_reg, weak_start_reg;
    logic          wr_en_reg, wr_vbit_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [31:0]   wr_start_reg, wr_fail_reg;
    logic          res_valid_reg, thr_reg, trip_reg;
    logic          res_thr_reg, res_trip_reg;

    logic [31:0]   win;
    logic [31:0]   age;
    logic          live, match;
    logic [31:0]   fail_inc;

    always_comb begin
        win   = (window_seconds == 16'd0) ? {16'd0, WINDOW_FALLBACK} : {16'd0, window_seconds};
        age   = cmd_reg.now_seconds - rd_start_reg;
        live  = rd_valid_reg && (cmd_reg.now_seconds >= rd_start_reg) && (age < win);
        match = rd_valid_reg && (rd_key_reg == cmd_reg.lookup_key);
        fail_inc = (rd_fail_reg == FAIL_MAX) ? rd_fail_reg : rd_fail_reg + 32'd1;
    end

    assign cmd_ready     = (state_reg == E_IDLE) && clear_done;
    assign res_valid     = res_valid_reg;
    assign res_throttled = res_thr_reg;
    assign res_tripped   = res_trip_reg;

    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_mem[addr_reg];
        rd_key_reg   <= key_mem[addr_reg];
        rd_start_reg <= start_mem[addr_reg];
        rd_fail_reg  <= fail_mem[addr_reg];
        if (wr_en_reg) begin
            valid_mem[wr_addr_reg] <= wr_vbit_reg;
            key_mem[wr_addr_reg]   <= cmd_reg.lookup_key;
            start_mem[wr_addr_reg] <= wr_start_reg;
            fail_mem[wr_addr_reg]  <= wr_fail_reg;
        end
        if (!clear_done) valid_mem[addr_reg] <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= E_IDLE;
            res_valid_reg <= 1'b0;
            wr_en_reg     <= 1'b0;
            addr_reg      <= '0;
        end else begin
            wr_en_reg <= 1'b0;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE: begin
                    if (!clear_done) begin
                        addr_reg <= addr_reg + 1'b1;
                    end else if (cmd_valid) begin
                        cmd_reg        <= cmd;
                        addr_reg       <= cmd.hash[AW-1:0];
                        probe_reg      <= '0;
                        have_reuse_reg <= 1'b0;
                        have_weak_reg  <= 1'b0;
                        thr_reg        <= 1'b0;
                        trip_reg       <= 1'b0;
                        state_reg      <= E_READ;
                    end
                end
                E_READ: state_reg <= E_EVAL;
                E_EVAL: begin
                    state_reg <= E_READ;
                    if (fail_threshold == 16'd0 ||
                        (cmd_reg.func != FUNC_QUERY && cmd_reg.func != FUNC_RECORD &&
                         cmd_reg.func != FUNC_CLEAR)) begin
                        state_reg <= E_DONE;
                    end else if (match) begin
                        state_reg   <= E_DONE;
                        wr_addr_reg <= addr_reg;
                        unique case (cmd_reg.func)
                            FUNC_QUERY: begin
                                thr_reg <= live && (rd_fail_reg >= {16'd0, fail_threshold});
                            end
                            FUNC_RECORD: begin
                                wr_en_reg    <= 1'b1;
                                wr_vbit_reg  <= 1'b1;
                                wr_start_reg <= live ? rd_start_reg : cmd_reg.now_seconds;
                                wr_fail_reg  <= live ? fail_inc : 32'd1;
                                trip_reg     <= (live ? fail_inc : 32'd1) ==
                                                {16'd0, fail_threshold};
                            end
                            default: begin
                                wr_en_reg    <= 1'b1;
                                wr_vbit_reg  <= 1'b0;
                                wr_start_reg <= '0;
                                wr_fail_reg  <= '0;
                            end
                        endcase
                    end else begin
                        if (!live) begin
                            if (!have_reuse_reg) begin
                                have_reuse_reg <= 1'b1;
                                reuse_reg      <= addr_reg;
                            end
                        end else if (!have_weak_reg || rd_fail_reg < weak_fail_reg ||
                                     (rd_fail_reg == weak_fail_reg &&
                                      rd_start_reg < weak_start_reg)) begin
                            have_weak_reg  <= 1'b1;
                            weak_reg       <= addr_reg;
                            weak_fail_reg  <= rd_fail_reg;
                            weak_start_reg <= rd_start_reg;
                        end
                        addr_reg  <= addr_reg + 1'b1;
                        probe_reg <= probe_reg + 1'b1;
                        if (probe_reg == PW'(PROBE_LEN - 1)) begin
                            state_reg <= (cmd_reg.func == FUNC_RECORD) ? E_WRITE : E_DONE;
                        end
                    end
                end
                E_WRITE: begin
                    wr_en_reg    <= 1'b1;
                    wr_vbit_reg  <= 1'b1;
                    wr_addr_reg  <= (have_reuse_reg || !live) ?
                                    ((have_reuse_reg) ? reuse_reg : addr_reg) : weak_reg;
                    wr_start_reg <= cmd_reg.now_seconds;
                    wr_fail_reg  <= 32'd1;
                    trip_reg     <= (fail_threshold == 16'd1);
                    state_reg    <= E_DONE;
                end
                E_DONE: if (!res_valid_reg || res_ready) begin
                    res_valid_reg <= 1'b1;
                    res_thr_reg   <= thr_reg;
                    res_trip_reg  <= trip_reg;
                    state_reg     <= E_IDLE;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/keyed_failure_rate_limiter.sv
// ---------------------------------------------------------------------------
// keyed_failure_rate_limiter: per-key fixed-window failure limiter
// Hash front, command queue and slot table engine.
// ---------------------------------------------------------------------------
// An item passes the front (eight FNV-1a rounds, one key byte per cycle) and
// then the table engine, which probes up to PROBE_LEN slots, reading one per
// READ/EVAL state pair and taking the next item only once idle; the engine
// sets the sustained rate. After reset the engine sweeps all SLOTS entries to
// clear valid bits, and accepts no item until that finishes.
`default_nettype none
module keyed_failure_rate_limiter #(
    parameter int SLOTS     = 1024,
    parameter int PROBE_LEN = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // func[1:0], lookup_key[65:2], now_seconds[97:66]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // throttled[0], tripped[1]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import kfrl_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [15:0]   fail_threshold_reg, window_seconds_reg;
    logic          clear_done_reg;
    logic [AW:0]   sweep_reg;
    logic          fq_valid, fq_ready, eq_valid, eq_ready;
    kfrl_cmd_t     fq_data, eq_data;
    logic          thr, trip;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_threshold_reg <= 16'd10;
            window_seconds_reg <= 16'd600;
            clear_done_reg     <= 1'b0;
            sweep_reg          <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_FAIL_THRESHOLD) fail_threshold_reg <= cfg_data;
                else                                 window_seconds_reg <= cfg_data;
            end
            if (!clear_done_reg) begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sweep_reg == (AW+1)'(SLOTS - 1)) clear_done_reg <= 1'b1;
            end
        end
    end

    kfrl_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_func(s_tdata[1:0]), .in_key(s_tdata[65:2]), .in_now(s_tdata[97:66]),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    kfrl_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(eq_valid), .rd_ready(eq_ready), .rd_data(eq_data)
    );

    kfrl_engine #(.SLOTS(SLOTS), .PROBE_LEN(PROBE_LEN)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(eq_valid), .cmd_ready(eq_ready), .cmd(eq_data),
        .fail_threshold(fail_threshold_reg), .window_seconds(window_seconds_reg),
        .clear_done(clear_done_reg),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_throttled(thr), .res_tripped(trip)
    );

    assign m_tdata = {6'd0, trip, thr};
endmodule
`default_nettype wire

// File: sv/kfrl_checker.sv
// ---------------------------------------------------------------------------
// kfrl_checker: port-level checks
// Result stability, field exclusivity and padding on the result channel, plus reset and input busy checks.
// ---------------------------------------------------------------------------
`default_nettype none
module kfrl_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [7:0]   m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("throttled and tripped both set");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:2] == 6'd0)
        else $error("padding bits set");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");
endmodule

bind keyed_failure_rate_limiter kfrl_checker u_kfrl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: keyed_failure_rate_limiter self-checking bench
// Drives query, record, clear and unused-code items under random stalls on both streams,
// mirrors the slot table in a scoreboard and checks every result item.
// ---------------------------------------------------------------------------
module testbench;
    import kfrl_pkg::*;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int NSLOT = 1024;
    localparam int PROBE = 8;

    class failure_scoreboard;
        bit          slot_used  [NSLOT];
        logic [63:0] slot_id    [NSLOT];
        logic [31:0] slot_start [NSLOT];
        logic [31:0] slot_count [NSLOT];
        logic [15:0] threshold = 16'd10;
        logic [15:0] window    = 16'd600;
        logic [1:0]  outcome_q [$];
        int errors  = 0;
        int results = 0;
        int trips   = 0;
        int throttles = 0;

        function logic [9:0] probe_base(logic [63:0] key);
            logic [31:0] h;
            h = FNV_BASIS;
            for (int b = 7; b >= 0; b--) begin
                h = h ^ {24'd0, key[8*b +: 8]};
                h = h * FNV_PRIME;
            end
            return h[9:0];
        endfunction

        function bit is_live(int s, logic [31:0] now);
            logic [31:0] span;
            span = (window == 16'd0) ? {16'd0, WINDOW_FALLBACK} : {16'd0, window};
            return slot_used[s] && now >= slot_start[s] && (now - slot_start[s]) < span;
        endfunction

        function void note_item(logic [1:0] func, logic [63:0] key, logic [31:0] now);
            logic [9:0] base;
            logic [9:0] s;
            bit throttled_o, tripped_o, found, have_free, have_weak;
            int free_s, weak_s, pick;
            base = probe_base(key);
            throttled_o = 0;
            tripped_o = 0;
            found = 0;
            have_free = 0;
            have_weak = 0;
            free_s = 0;
            weak_s = 0;
            pick = 0;
            if (threshold != 16'd0) begin
                for (int i = 0; i < PROBE && !found; i++) begin
                    s = base + i[9:0];
                    if (slot_used[s] && slot_id[s] === key) begin
                        found = 1;
                        pick = s;
                    end else if (!is_live(s, now)) begin
                        if (!have_free) begin
                            have_free = 1;
                            free_s = s;
                        end
                    end else if (!have_weak || slot_count[s] < slot_count[weak_s] ||
                                 (slot_count[s] == slot_count[weak_s] &&
                                  slot_start[s] < slot_start[weak_s])) begin
                        have_weak = 1;
                        weak_s = s;
                    end
                end
                case (func)
                    FUNC_QUERY: begin
                        throttled_o = found && is_live(pick, now) &&
                                      slot_count[pick] >= {16'd0, threshold};
                    end
                    FUNC_RECORD: begin
                        if (found) begin
                            if (!is_live(pick, now)) begin
                                slot_start[pick] = now;
                                slot_count[pick] = 0;
                            end
                        end else begin
                            pick = have_free ? free_s : weak_s;
                            slot_used[pick]  = 1;
                            slot_id[pick]    = key;
                            slot_start[pick] = now;
                            slot_count[pick] = 0;
                        end
                        if (slot_count[pick] != FAIL_MAX)
                            slot_count[pick] = slot_count[pick] + 1;
                        tripped_o = slot_count[pick] == {16'd0, threshold};
                    end
                    FUNC_CLEAR: begin
                        if (found) begin
                            slot_used[pick]  = 0;
                            slot_start[pick] = 0;
                            slot_count[pick] = 0;
                        end
                    end
                    default: ;
                endcase
            end
            outcome_q.push_back({tripped_o, throttled_o});
        endfunction

        function void check_result(logic [7:0] got);
            logic [1:0] want;
            results++;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result item %h", got);
                return;
            end
            want = outcome_q.pop_front();
            trips += want[1];
            throttles += want[0];
            if (got[0] !== want[0] || got[1] !== want[1]) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d throttled exp %b got %b, tripped exp %b got %b",
                             results, want[0], got[0], want[1], got[1]);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    failure_scoreboard board = new();
    bit          steady = 0;
    int          sent = 0;
    logic [31:0] clock_now = 32'd1000;
    logic [63:0] crowd [16];
    logic [63:0] pool  [40];

    keyed_failure_rate_limiter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
        m_tready <= steady || ($urandom_range(99) >= 27);
    end

    task automatic send_item(logic [1:0] func, logic [63:0] key, logic [31:0] now);
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {30'd0, now, key, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(func, key, now);
        sent++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.outcome_q.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_FAIL_THRESHOLD)
            board.threshold = value;
        else
            board.window = value;
    endtask

    task automatic random_items(int count);
        logic [1:0]  func;
        logic [63:0] key;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            func = roll < 40 ? FUNC_RECORD : roll < 75 ? FUNC_QUERY :
                   roll < 93 ? FUNC_CLEAR : FUNC_UNUSED;
            roll = $urandom_range(99);
            key = roll < 50 ? crowd[$urandom_range(15)] :
                  roll < 85 ? pool[$urandom_range(39)] : {$urandom, $urandom};
            roll = $urandom_range(99);
            if (roll < 2)
                clock_now = $urandom;
            else if (roll < 5)
                clock_now = clock_now - $urandom_range(30);
            else if (roll < 10)
                clock_now = clock_now + $urandom_range(700);
            else
                clock_now = clock_now + $urandom_range(2);
            send_item(func, key, clock_now);
        end
    endtask

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int found;
        logic [63:0] k;
        found = 0;
        while (found < 16) begin
            k = {$urandom, $urandom};
            if (board.probe_base(k) >= 10'd512 && board.probe_base(k) <= 10'd514) begin
                crowd[found] = k;
                found++;
            end
        end
        foreach (pool[i]) pool[i] = {$urandom, $urandom};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(FUNC_QUERY, 64'd0, 32'd0);
        for (int i = 0; i < 10; i++) send_item(FUNC_RECORD, 64'd0, 32'd5);
        send_item(FUNC_QUERY, 64'd0, 32'd604);
        send_item(FUNC_QUERY, 64'd0, 32'd605);
        send_item(FUNC_QUERY, 64'd0, 32'd4);
        send_item(FUNC_CLEAR, 64'd0, 32'd6);
        send_item(FUNC_QUERY, 64'd0, 32'd6);
        send_item(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++) send_item(FUNC_RECORD, crowd[i], 32'd50 + i);

        random_items(250);
        write_reg(REG_FAIL_THRESHOLD, 16'd3);
        write_reg(REG_WINDOW_SECONDS, 16'd4);
        random_items(250);
        write_reg(REG_FAIL_THRESHOLD, 16'd1);
        write_reg(REG_WINDOW_SECONDS, 16'd1);
        steady = 1;
        random_items(250);
        steady = 0;
        write_reg(REG_FAIL_THRESHOLD, 16'd65535);
        write_reg(REG_WINDOW_SECONDS, 16'd65535);
        random_items(200);
        write_reg(REG_FAIL_THRESHOLD, 16'd0);
        random_items(150);
        write_reg(REG_FAIL_THRESHOLD, 16'd2);
        write_reg(REG_WINDOW_SECONDS, 16'd0);
        random_items(300);
        write_reg(REG_FAIL_THRESHOLD, 16'd5);
        write_reg(REG_WINDOW_SECONDS, 16'd20);
        random_items(300);

        s_tvalid <= 1'b0;
        while (board.outcome_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.outcome_q.size() != 0)
            board.errors += board.outcome_q.size();
        $display("Sent %0d items over seven threshold/window settings, %0d results checked",
                 sent, board.results);
        $display("Saw %0d trips and %0d throttled queries, %0d errors",
                 board.trips, board.throttles, board.errors);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
